// ===== design/rsaped_pkg.sv =====
package rsaped_pkg;

    localparam int WORD_BITS = 64;
    localparam int HALF_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;         // capture a new request
        logic mul_n;        // modulus product
        logic mul_t;        // totient product
        logic div_ld_mod;   // divide exponent by totient
        logic div_ld_loop;  // divide r0 by r1
        logic div_ld_norm;  // divide m0 by totient
        logic div_step;     // one restoring division step
        logic red_upd;      // seed the Euclid pairs
        logic euc_upd;      // advance the Euclid pairs
        logic finish;       // form the result
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic t_zero;
        logic r1_zero;
        logic div_last;
    } dp_stat_t;

endpackage

// ===== design/rsaped_ctrl.sv =====
module rsaped_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rsaped_pkg::dp_stat_t stat,
    output rsaped_pkg::dp_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_MUL_N    = 11'b000_0000_0010,
        S_MUL_T    = 11'b000_0000_0100,
        S_CHECK    = 11'b000_0000_1000,
        S_DIV_MOD  = 11'b000_0001_0000,
        S_RED      = 11'b000_0010_0000,
        S_LOOP_CHK = 11'b000_0100_0000,
        S_DIV_LOOP = 11'b000_1000_0000,
        S_EUC_UPD  = 11'b001_0000_0000,
        S_DIV_NORM = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_N;
                end
            end
            S_MUL_N:
            begin
                cmd.mul_n  = 1'b1;
                state_next = S_MUL_T;
            end
            S_MUL_T:
            begin
                cmd.mul_t  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.t_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_ld_mod = 1'b1;
                    state_next     = S_DIV_MOD;
                end
            end
            S_DIV_MOD:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                cmd.red_upd = 1'b1;
                state_next  = S_LOOP_CHK;
            end
            S_LOOP_CHK:
            begin
                if (stat.r1_zero)
                begin
                    cmd.div_ld_norm = 1'b1;
                    state_next      = S_DIV_NORM;
                end
                else
                begin
                    cmd.div_ld_loop = 1'b1;
                    state_next      = S_DIV_LOOP;
                end
            end
            S_DIV_LOOP:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_EUC_UPD;
                end
            end
            S_EUC_UPD:
            begin
                cmd.euc_upd = 1'b1;
                state_next  = S_LOOP_CHK;
            end
            S_DIV_NORM:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next = (state_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== design/rsaped_datapath.sv =====
module rsaped_datapath (
    input  logic                                  clk,
    input  rsaped_pkg::dp_cmd_t                   cmd,
    input  logic [rsaped_pkg::HALF_BITS-1:0]      prime_p,
    input  logic [rsaped_pkg::HALF_BITS-1:0]      prime_q,
    input  logic [rsaped_pkg::WORD_BITS-1:0]      exponent,
    output rsaped_pkg::dp_stat_t                  stat,
    output logic [rsaped_pkg::WORD_BITS-1:0]      modulus,
    output logic [rsaped_pkg::WORD_BITS-1:0]      totient,
    output logic                                  coprime,
    output logic [rsaped_pkg::WORD_BITS-1:0]      inverse
);

    localparam int W = rsaped_pkg::WORD_BITS;
    localparam int H = rsaped_pkg::HALF_BITS;

    logic [H-1:0] p_reg, q_reg;
    logic [W-1:0] e_reg, n_reg, t_reg;
    logic [W-1:0] r0_reg, r1_reg, m0_reg, m1_reg;
    logic         par_reg;
    logic [W-1:0] rem_reg, quo_reg, dvs_reg, acc_reg;
    logic [rsaped_pkg::CNT_BITS-1:0] cnt_reg;
    logic [W-1:0] mod_out_reg, tot_out_reg, inv_out_reg;
    logic         cop_out_reg;

    logic [H-1:0] pm, qm, mul_a, mul_b;
    logic [W-1:0] product;
    logic [W:0]   shifted, diff;
    logic         ge;
    logic         cop_next;
    logic [W-1:0] inv_next;

    // Saturate p-1 and q-1 at zero
    assign pm = (p_reg == '0) ? '0 : p_reg - H'(1);
    assign qm = (q_reg == '0) ? '0 : q_reg - H'(1);

    assign mul_a   = cmd.mul_t ? pm : p_reg;
    assign mul_b   = cmd.mul_t ? qm : q_reg;
    assign product = W'(mul_a) * W'(mul_b);

    // Restoring division step; quotient bits also drive a Horner
    // accumulation of quotient times m1.
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = !diff[W];

    assign cop_next = (t_reg != '0) && (r0_reg == W'(1));

    always_comb
    begin
        if (!cop_next)
        begin
            inv_next = '0;
        end
        else if (par_reg)
        begin
            inv_next = rem_reg;
        end
        else if (rem_reg == '0)
        begin
            inv_next = '0;
        end
        else
        begin
            inv_next = t_reg - rem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg <= prime_p;
            q_reg <= prime_q;
            e_reg <= exponent;
        end
        if (cmd.mul_n)
        begin
            n_reg <= product;
        end
        if (cmd.mul_t)
        begin
            t_reg <= product;
        end

        if (cmd.div_ld_mod || cmd.div_ld_loop || cmd.div_ld_norm)
        begin
            rem_reg <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_ld_mod)
        begin
            quo_reg <= e_reg;
            dvs_reg <= t_reg;
        end
        if (cmd.div_ld_loop)
        begin
            quo_reg <= r0_reg;
            dvs_reg <= r1_reg;
        end
        if (cmd.div_ld_norm)
        begin
            quo_reg <= m0_reg;
            dvs_reg <= t_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
            acc_reg <= {acc_reg[W-2:0], 1'b0} + (ge ? m1_reg : '0);
            cnt_reg <= cnt_reg + rsaped_pkg::CNT_BITS'(1);
        end

        if (cmd.red_upd)
        begin
            r0_reg  <= t_reg;
            r1_reg  <= rem_reg;
            m0_reg  <= '0;
            m1_reg  <= W'(1);
            par_reg <= 1'b0;
        end
        if (cmd.euc_upd)
        begin
            r0_reg  <= r1_reg;
            r1_reg  <= rem_reg;
            m0_reg  <= m1_reg;
            m1_reg  <= m0_reg + acc_reg;
            par_reg <= !par_reg;
        end

        if (cmd.finish)
        begin
            mod_out_reg <= n_reg;
            tot_out_reg <= t_reg;
            cop_out_reg <= cop_next;
            inv_out_reg <= inv_next;
        end
    end

    assign stat.t_zero   = (t_reg == '0);
    assign stat.r1_zero  = (r1_reg == '0);
    assign stat.div_last = (cnt_reg == rsaped_pkg::CNT_LAST);

    assign modulus = mod_out_reg;
    assign totient = tot_out_reg;
    assign coprime = cop_out_reg;
    assign inverse = inv_out_reg;

endmodule

// ===== design/rsa_private_exponent_derivation_top.sv =====
// RSA key derivation: a request carries primes p and q and a public exponent e; the
// block returns n = p*q, the totient (p-1)(q-1), a coprime flag for gcd(e, totient) = 1
// and the private exponent d = e^-1 mod totient (0 when not coprime). Raise start while
// busy is low to issue a request; busy stays high until the cycle in which the result
// is out. The result appears for exactly one cycle with done high and the receiver
// cannot stall it, so capture it then; the result ports hold their value until the next
// result. A request passes through the two products and the totient check, then the
// reduction of e, one division per Euclid round (up to about 93 rounds for 64-bit
// words) and the final normalization before the result cycle; the divisions share the
// single bit-serial restoring divider, which also accumulates the coefficient product.
// A zero totient skips the divider.
module rsa_private_exponent_derivation_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [rsaped_pkg::HALF_BITS-1:0] prime_p,
    input  logic [rsaped_pkg::HALF_BITS-1:0] prime_q,
    input  logic [rsaped_pkg::WORD_BITS-1:0] exponent,
    output logic                             done,
    output logic [rsaped_pkg::WORD_BITS-1:0] modulus,
    output logic [rsaped_pkg::WORD_BITS-1:0] totient,
    output logic                             coprime,
    output logic [rsaped_pkg::WORD_BITS-1:0] inverse
);

    rsaped_pkg::dp_cmd_t  cmd;
    rsaped_pkg::dp_stat_t stat;

    // Sequence the products, the divisions and the Euclid updates
    rsaped_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Hold the operands, the Euclid pairs, the divider and the result
    rsaped_datapath u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .prime_p  (prime_p),
        .prime_q  (prime_q),
        .exponent (exponent),
        .stat     (stat),
        .modulus  (modulus),
        .totient  (totient),
        .coprime  (coprime),
        .inverse  (inverse)
    );

    // An accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // Done goes low in the cycle after it is high
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // A non-coprime result carries a zero inverse
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !coprime |-> inverse == '0)
        else $error("inverse nonzero without coprime flag");

    // The inverse lies below the totient
    a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && coprime |-> (totient != '0) && (inverse < totient))
        else $error("inverse out of range");

endmodule
